### design/rlm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlm_pkg
// shared types and codes of the resource lock manager
// ---------------------------------------------------------------------------
package rlm_pkg;

   localparam int ProcW   = 4;
   localparam int ResW    = 4;
   localparam int StatusW = 3;
   localparam int PresW   = 5;

   // operation codes
   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // status codes
   localparam logic [StatusW-1:0] ST_GRANTED   = 3'd0;
   localparam logic [StatusW-1:0] ST_QUEUED    = 3'd1;
   localparam logic [StatusW-1:0] ST_RELEASED  = 3'd2;
   localparam logic [StatusW-1:0] ST_REL_ERROR = 3'd3;
   localparam logic [StatusW-1:0] ST_DROPPED   = 3'd4;

   localparam logic [PresW-1:0] PRESENT_RESET = 5'd16;

   typedef struct packed {
      logic            operation;
      logic [ProcW-1:0] process;
      logic [ResW-1:0]  resource;
   } req_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic               woke_valid;
      logic [ProcW-1:0]   woke_process;
   } rsp_type;

   typedef struct packed {
      logic [ProcW-1:0] process;
      logic [ResW-1:0]  resource;
   } wait_entry_type;

endpackage

### design/resource_lock_manager_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// resource_lock_manager_top
// mutex lock manager with a shared fifo wait queue
// ---------------------------------------------------------------------------
// usage: each req_ transfer is a request or release of one resource by one
// process; exactly one rsp_ transfer follows with status and the woken waiter.
// req_stall is high from the accepting edge until the result is loaded into
// the output register, so one item is in flight at a time.
// a request or a failed release passes through DECIDE to FINISH, which raises
// rsp_valid; req_stall falls at the same edge.
// a good release scans the wait queue memory through one compare unit, one
// entry per cycle, and closes the gap behind the matching waiter in the same
// pass, then goes to FINISH; the scan grows with the number of queued entries.
// the queue memory has a registered read port, so each entry is compared once
// its read data is registered.
// when rsp_stall holds the output register, the finished result waits in
// the finish state and req_stall stays high; a pending result is held stable.
// csr_write_enable loads resources_present; write it only while idle.
// reset (synchronous, active high) frees every resource, empties the queue,
// sets resources_present to 16 and drops any pending result.
// ---------------------------------------------------------------------------
module resource_lock_manager_top
   import rlm_pkg::*;
#(
   parameter int NUM_RESOURCES = 16,
   parameter int WAIT_DEPTH    = 16
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   // configuration
   input  logic             csr_write_enable,
   input  logic [PresW-1:0] csr_write_data
);

   // only ids reachable by the resource field need owner storage
   localparam int OwnDepth = (NUM_RESOURCES < (1 << ResW)) ? NUM_RESOURCES : (1 << ResW);
   localparam int OwnIw    = (OwnDepth > 1) ? $clog2(OwnDepth) : 1;
   localparam int Iw       = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int Cw       = $clog2(WAIT_DEPTH + 1);
   localparam logic [8:0]    NumResW = 9'(NUM_RESOURCES);
   localparam logic [Cw-1:0] DepthW  = Cw'(WAIT_DEPTH);

   typedef enum logic [1:0] {
      IDLE,
      DECIDE,
      SCAN,
      FINISH
   } state_type;

   // control and result registers
   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   rsp_type              result_ff, result_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [PresW-1:0]     present_ff, present_in;
   logic [Cw-1:0]        count_ff, count_in;
   // scan unit
   logic [Cw-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [Iw-1:0]        chk_ptr_ff, chk_ptr_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic                 found_ff, found_in;
   // owner table
   logic [OwnDepth-1:0]  owner_valid_ff, owner_valid_in;
   logic [ProcW-1:0]     owner_proc_ff [OwnDepth];
   logic [ProcW-1:0]     owner_proc_in [OwnDepth];

   // wait queue memory
   wait_entry_type       wait_mem [WAIT_DEPTH];
   wait_entry_type       rd_data_ff;
   logic                 mem_we;
   logic [Iw-1:0]        mem_wa;
   wait_entry_type       mem_wd;
   logic [Iw-1:0]        mem_ra;

   logic                 res_exists;
   logic [OwnIw-1:0]     own_idx;
   logic                 issue;

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // existence check against the register and the table size
   assign res_exists = ({1'b0, req_ff.resource} < present_ff) &&
                       ({5'd0, req_ff.resource} < NumResW);
   assign own_idx    = res_exists ? req_ff.resource[OwnIw-1:0] : '0;

   // another queue entry still to be read
   assign issue = (rd_ptr_ff < count_ff);

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      present_in     = present_ff;
      count_in       = count_ff;
      rd_ptr_in      = rd_ptr_ff;
      chk_ptr_in     = chk_ptr_ff;
      chk_vld_in     = chk_vld_ff;
      found_in       = found_ff;
      owner_valid_in = owner_valid_ff;
      owner_proc_in  = owner_proc_ff;
      mem_we         = 1'b0;
      mem_wa         = '0;
      mem_wd         = rd_data_ff;
      mem_ra         = '0;

      if (csr_write_enable) begin
         present_in = csr_write_data;
      end

      // output register drains on a transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = DECIDE;
            end
         end

         DECIDE: begin
            result_in.woke_valid   = 1'b0;
            result_in.woke_process = '0;
            state_in               = FINISH;
            if (req_ff.operation == OP_REQUEST) begin
               if (res_exists && !owner_valid_ff[own_idx]) begin
                  owner_valid_in[own_idx] = 1'b1;
                  owner_proc_in[own_idx]  = req_ff.process;
                  result_in.status        = ST_GRANTED;
               end else if (count_ff < DepthW) begin
                  // append at the tail
                  mem_we           = 1'b1;
                  mem_wa           = count_ff[Iw-1:0];
                  mem_wd.process   = req_ff.process;
                  mem_wd.resource  = req_ff.resource;
                  count_in         = count_ff + 1'b1;
                  result_in.status = ST_QUEUED;
               end else begin
                  result_in.status = ST_DROPPED;
               end
            end else begin
               if (res_exists && owner_valid_ff[own_idx] &&
                   (owner_proc_ff[own_idx] == req_ff.process)) begin
                  owner_valid_in[own_idx] = 1'b0;
                  result_in.status        = ST_RELEASED;
                  rd_ptr_in               = '0;
                  chk_vld_in              = 1'b0;
                  found_in                = 1'b0;
                  state_in                = SCAN;
               end else begin
                  result_in.status = ST_REL_ERROR;
               end
            end
         end

         SCAN: begin
            // read side: one entry per cycle, data checked from the read register
            chk_vld_in = issue;
            if (issue) begin
               mem_ra     = rd_ptr_ff[Iw-1:0];
               rd_ptr_in  = rd_ptr_ff + 1'b1;
               chk_ptr_in = rd_ptr_ff[Iw-1:0];
            end
            if (chk_vld_ff) begin
               if (!found_ff) begin
                  // oldest waiter for this resource
                  if (rd_data_ff.resource == req_ff.resource) begin
                     found_in               = 1'b1;
                     result_in.woke_valid   = 1'b1;
                     result_in.woke_process = rd_data_ff.process;
                  end
               end else begin
                  // shift entries behind the gap down by one
                  mem_we = 1'b1;
                  mem_wa = chk_ptr_ff - Iw'(1);
                  mem_wd = rd_data_ff;
               end
            end
            if (!issue && !chk_vld_ff) begin
               if (found_ff) begin
                  count_in = count_ff - 1'b1;
               end
               state_in = FINISH;
            end
         end

         FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         rsp_valid_ff   <= 1'b0;
         present_ff     <= PRESENT_RESET;
         count_ff       <= '0;
         chk_vld_ff     <= 1'b0;
         found_ff       <= 1'b0;
         owner_valid_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         present_ff     <= present_in;
         count_ff       <= count_in;
         chk_vld_ff     <= chk_vld_in;
         found_ff       <= found_in;
         owner_valid_ff <= owner_valid_in;
      end
      req_ff        <= req_in;
      result_ff     <= result_in;
      rsp_data_ff   <= rsp_data_in;
      rd_ptr_ff     <= rd_ptr_in;
      chk_ptr_ff    <= chk_ptr_in;
      owner_proc_ff <= owner_proc_in;
   end

   // queue memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wait_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= wait_mem[mem_ra];
   end

endmodule

### verif/resource_lock_manager_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// resource_lock_manager_top_tb
// self-checking bench for the resource lock manager
// ---------------------------------------------------------------------------
// a directed opening walks grant, busy and owner re-requests, foreign and
// free releases, wakeups with and without a waiter, nonexistent ids and a
// full wait queue. random phases follow at several resources_present
// settings, mostly owner releases and live requests built from the current
// lock state, with noise mixed in. every accepted request transfer updates
// a local lock table and wait queue that predict the one result it causes;
// each result transfer is checked field by field against the oldest
// prediction. the sender idles in bursts and the receiver stalls in runs.
// ---------------------------------------------------------------------------
module resource_lock_manager_top_tb;
   import rlm_pkg::*;

   localparam int NUM_RES       = 16;
   localparam int WAIT_DEPTH    = 16;
   localparam int RESET_CYCLES  = 8;
   localparam int DRAIN_CYCLES  = 30;       // longer than a full-queue release
   localparam int CYCLE_LIMIT   = 600000;   // several times the slowest legal run
   localparam int PRINT_LIMIT   = 200;

   // clock, reset and dut ports; the bench-driven ones are known from time zero
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [PresW-1:0] csr_write_data = '0;

   // lock table and wait queue as the bench believes them to be
   bit                 lock_held  [NUM_RES];
   logic [ProcW-1:0]   lock_owner [NUM_RES];
   wait_entry_type     waiters [$];
   logic [PresW-1:0]   present_reg = PRESENT_RESET;

   // request items not yet driven, results not yet seen
   req_type            pending_q  [$];
   rsp_type            expected_q [$];

   // phase controls, changed only while the block is idle
   bit                 sender_gaps     = 1'b1;
   bit                 receiver_stalls = 1'b1;

   int                 error_count = 0;
   int                 cycle_count = 0;

   // driver and receiver pacing
   int                 burst_left = 0;
   int                 gap_left   = 0;
   int                 run_left   = 0;
   bit                 stall_now  = 1'b0;
   rsp_type            want;

   resource_lock_manager_top #(
      .NUM_RESOURCES (NUM_RES),
      .WAIT_DEPTH    (WAIT_DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // prediction: apply one accepted item to the lock table, return its result
   // ------------------------------------------------------------------------
   function automatic rsp_type predict_lock(req_type item);
      rsp_type        result;
      wait_entry_type entry;
      bit             exists;
      int             idx;
      int             hit;
      result = '0;
      // ids at or above the register, or past the table, do not exist
      exists = (int'(item.resource) < int'(present_reg)) && (int'(item.resource) < NUM_RES);
      if (item.operation == OP_REQUEST) begin
         if (exists && !lock_held[item.resource]) begin
            lock_held[item.resource]  = 1'b1;
            lock_owner[item.resource] = item.process;
            result.status = ST_GRANTED;
         end else if (waiters.size() < WAIT_DEPTH) begin
            // busy, nonexistent or owner asking again: all join the queue
            entry.process  = item.process;
            entry.resource = item.resource;
            waiters.push_back(entry);
            result.status = ST_QUEUED;
         end else begin
            result.status = ST_DROPPED;
         end
      end else if (exists && lock_held[item.resource] &&
                   lock_owner[item.resource] == item.process) begin
         // owner release frees the lock; the oldest waiter on it is woken
         // and pulled out of the queue, but does not get the lock
         lock_held[item.resource] = 1'b0;
         result.status = ST_RELEASED;
         hit = -1;
         for (idx = 0; idx < waiters.size() && hit < 0; idx++) begin
            if (waiters[idx].resource == item.resource) hit = idx;
         end
         if (hit >= 0) begin
            result.woke_valid   = 1'b1;
            result.woke_process = waiters[hit].process;
            waiters.delete(hit);
         end
      end else begin
         result.status = ST_REL_ERROR;
      end
      return result;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   // one random item shaped by the current lock table: mostly owner releases
   // and requests on live ids, plus foreign releases and owner re-requests
   function automatic req_type make_lock_item(int release_pct);
      req_type          item;
      logic [ResW-1:0]  owned [$];
      int               roll;
      int               live;
      int               idx;
      logic [ResW-1:0]  pick;
      item.operation = OP_REQUEST;
      item.process   = ProcW'($urandom_range(0, 15));
      item.resource  = ResW'($urandom_range(0, 15));
      live = (int'(present_reg) > NUM_RES) ? NUM_RES : int'(present_reg);
      for (idx = 0; idx < NUM_RES; idx++) begin
         if (lock_held[idx]) owned.push_back(ResW'(idx));
      end
      roll = $urandom_range(0, 99);
      if (roll < release_pct && owned.size() != 0) begin
         pick = owned[$urandom_range(0, owned.size() - 1)];
         item.operation = OP_RELEASE;
         item.resource  = pick;
         item.process   = lock_owner[pick];
      end else if (roll < release_pct + 8) begin
         item.operation = OP_RELEASE;   // most likely a foreign or free release
      end else if (roll < release_pct + 13 && owned.size() != 0) begin
         pick = owned[$urandom_range(0, owned.size() - 1)];
         item.resource = pick;
         item.process  = lock_owner[pick];
      end else if (live > 0 && roll % 8 != 0) begin
         item.resource = ResW'($urandom_range(0, live - 1));
      end
      return item;
   endfunction

   task automatic add_item(input logic op, input int proc, input int res);
      req_type item;
      item.operation = op;
      item.process   = ProcW'(proc);
      item.resource  = ResW'(res);
      pending_q.push_back(item);
   endtask

   // idle means every item transferred, every result seen, then a margin
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_present(input logic [PresW-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      present_reg = value;
   endtask

   // refill in small chunks so each item is built from a nearly current table
   task automatic run_phase(input logic [PresW-1:0] present, input int items,
                            input int release_pct, input bit gaps, input bit stalls);
      int made;
      int chunk;
      int k;
      wait_drained();
      write_present(present);
      sender_gaps     = gaps;
      receiver_stalls = stalls;
      made = 0;
      while (made < items) begin
         @(negedge clock);
         if (pending_q.size() == 0) begin
            chunk = $urandom_range(1, 3);
            for (k = 0; k < chunk && made < items; k++) begin
               pending_q.push_back(make_lock_item(release_pct));
               made++;
            end
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // ------------------------------------------------------------------------
   // driver: bursts of transfers with random gaps, payload held while stalled
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_data   <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         // request transfer at this edge: predict its result now
         if (req_valid && !req_stall) expected_q.push_back(predict_lock(req_data));
         // slot is free once the item went through or nothing was offered
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               req_data  <= pending_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // end of burst: pick the next burst and the gap after this item
                  burst_left = $urandom_range(0, 10);
                  if (!sender_gaps) gap_left = 0;
                  else if ($urandom_range(0, 1) == 0) gap_left = $urandom_range(1, 4);
                  else gap_left = $urandom_range(5, 40);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: check each result transfer, and drive the stall pattern
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         run_left  = 0;
         stall_now = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result with none expected, status %0d",
                                         rsp_data.status));
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.woke_valid !== want.woke_valid)
                  report_mismatch($sformatf("woke_valid %0b, expected %0b",
                                            rsp_data.woke_valid, want.woke_valid));
               if (rsp_data.woke_process !== want.woke_process)
                  report_mismatch($sformatf("woke_process %0d, expected %0d",
                                            rsp_data.woke_process, want.woke_process));
            end
         end
         // alternate free and stalled runs; mostly short stalls, some long
         if (run_left > 0) begin
            run_left--;
         end else begin
            stall_now = receiver_stalls ? !stall_now : 1'b0;
            if (!stall_now) run_left = $urandom_range(0, 15);
            else if ($urandom_range(0, 3) == 0) run_left = $urandom_range(4, 25);
            else run_left = $urandom_range(0, 3);
         end
         rsp_stall <= stall_now;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, all resources present after reset
      add_item(OP_REQUEST, 0, 0);     // free lock: granted
      add_item(OP_REQUEST, 3, 0);     // busy: queued
      add_item(OP_REQUEST, 0, 0);     // owner asks again: queued too
      add_item(OP_RELEASE, 5, 0);     // foreign release: error
      add_item(OP_RELEASE, 0, 0);     // owner release wakes the oldest waiter
      add_item(OP_RELEASE, 0, 0);     // lock is free now: error
      add_item(OP_REQUEST, 7, 0);
      add_item(OP_RELEASE, 7, 0);     // wakes the owner's duplicate wait
      add_item(OP_REQUEST, 12, 0);
      add_item(OP_RELEASE, 12, 0);    // nobody waiting: released, no wakeup
      wait_drained();

      // directed, only four resources present
      write_present(5'd4);
      @(negedge clock);
      add_item(OP_REQUEST, 15, 15);   // nonexistent id: queued
      add_item(OP_RELEASE, 15, 15);   // nonexistent id: error
      add_item(OP_REQUEST, 2, 3);
      for (int i = 0; i < WAIT_DEPTH - 1; i++) add_item(OP_REQUEST, (i * 5) % 12, 3);
      add_item(OP_REQUEST, 4, 3);     // queue full: dropped
      add_item(OP_RELEASE, 2, 3);     // wakeup from behind the head of the queue

      // random phases over the register range, extremes included
      run_phase(5'd0,  100, 40, 1'b1, 1'b1);
      run_phase(5'd31, 220, 45, 1'b0, 1'b0);   // above the id range, no idling
      run_phase(5'd1,  120, 45, 1'b1, 1'b1);
      run_phase(5'd16, 300, 30, 1'b1, 1'b1);   // request heavy, fills the queue
      run_phase(5'd8,  250, 50, 1'b1, 1'b0);
      run_phase(5'd15, 200, 45, 1'b0, 1'b1);
      run_phase(5'd16, 260, 55, 1'b1, 1'b1);   // release heavy, drains the queue

      wait_drained();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
